/* hdl/cbz_pkg.sv */
package cbz_pkg;

  localparam int SYMBOL_COUNT_DEF  = 256;
  localparam int COUNT_BITS_DEF    = 20;
  localparam int MAX_PROB_BITS_DEF = 16;

  localparam int         TBL_W           = 16;
  localparam logic [4:0] PROB_BITS_RESET = 5'd12;

  localparam logic [1:0] OPC_COUNT = 2'd0;
  localparam logic [1:0] OPC_BUILD = 2'd1;
  localparam logic [1:0] OPC_READ  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NO_DONOR = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE, S_CNT_RD, S_CNT_WR, S_TBL_RD, S_TBL_RES, S_B_START, S_ZF,
    S_B_RD, S_B_ACC, S_B_MUL, S_B_DIVI, S_B_DIV, S_B_WR, S_R_START,
    S_R_RDA, S_R_RDB, S_R_CHK, S_R_NEXT, S_F_INIT, S_F_FIRST, S_F_SCAN,
    S_F_DEC, S_S_RD, S_S_WR, S_FIN_OK, S_FIN_ND, S_CLR, S_FINISH
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_TAKE, OP_CNT_RD, OP_CNT_WR, OP_TBL_RD, OP_RD_RES,
    OP_ZF_INIT, OP_ZF_WR, OP_B_INIT, OP_B_RD, OP_B_ACC, OP_B_MUL,
    OP_DIV_INIT, OP_DIV_STEP, OP_B_WR, OP_R_INIT, OP_R_RDA, OP_R_RDB,
    OP_R_NEXT, OP_F_INIT, OP_F_FIRST, OP_F_SCAN, OP_S_INIT, OP_S_RD,
    OP_S_WR, OP_FIN_OK, OP_FIN_ND, OP_CLR, OP_LOAD
  } dp_op_t;

  typedef struct packed {
    logic total_zero;
    logic ptr_end;
    logic ptr_top;
    logic div_last;
    logic same;
    logic jp_top;
    logic jp_hi;
    logic found;
    logic out_free;
  } dp_status_t;

endpackage

/* hdl/cbz_ctrl.sv */
module cbz_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  cbz_pkg::dp_status_t st,
  output cbz_pkg::dp_op_t    op
);
  import cbz_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (opcode)
            OPC_COUNT: state_next = S_CNT_RD;
            OPC_BUILD: state_next = S_B_START;
            OPC_READ:  state_next = S_TBL_RD;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_CNT_RD:  state_next = S_CNT_WR;
      S_CNT_WR:  state_next = S_IDLE;
      S_TBL_RD:  state_next = S_TBL_RES;
      S_TBL_RES: state_next = S_FINISH;
      S_B_START: state_next = st.total_zero ? S_ZF : S_B_RD;
      S_ZF:      if (st.ptr_end) state_next = S_CLR;
      S_B_RD:    state_next = S_B_ACC;
      S_B_ACC:   state_next = S_B_MUL;
      S_B_MUL:   state_next = S_B_DIVI;
      S_B_DIVI:  state_next = S_B_DIV;
      S_B_DIV:   if (st.div_last) state_next = S_B_WR;
      S_B_WR:    state_next = st.ptr_top ? S_R_START : S_B_RD;
      S_R_START: state_next = S_R_RDA;
      S_R_RDA:   state_next = S_R_RDB;
      S_R_RDB:   state_next = S_R_CHK;
      S_R_CHK: begin
        if (st.same)         state_next = S_F_INIT;
        else if (st.ptr_top) state_next = S_FIN_OK;
        else                 state_next = S_R_NEXT;
      end
      S_R_NEXT:  state_next = S_R_RDA;
      S_F_INIT:  state_next = S_F_FIRST;
      S_F_FIRST: state_next = S_F_SCAN;
      S_F_SCAN:  if (st.jp_top) state_next = S_F_DEC;
      S_F_DEC:   state_next = st.found ? S_S_RD : S_FIN_ND;
      S_S_RD:    state_next = S_S_WR;
      S_S_WR: begin
        if (!st.jp_hi)       state_next = S_S_RD;
        else if (st.ptr_top) state_next = S_FIN_OK;
        else                 state_next = S_R_NEXT;
      end
      S_FIN_OK:  state_next = S_CLR;
      S_FIN_ND:  state_next = S_CLR;
      S_CLR:     state_next = S_FINISH;
      S_FINISH:  if (st.out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    op       = OP_NONE;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) op = OP_TAKE;
      end
      S_CNT_RD:  op = OP_CNT_RD;
      S_CNT_WR:  op = OP_CNT_WR;
      S_TBL_RD:  op = OP_TBL_RD;
      S_TBL_RES: op = OP_RD_RES;
      S_B_START: op = st.total_zero ? OP_ZF_INIT : OP_B_INIT;
      S_ZF:      op = OP_ZF_WR;
      S_B_RD:    op = OP_B_RD;
      S_B_ACC:   op = OP_B_ACC;
      S_B_MUL:   op = OP_B_MUL;
      S_B_DIVI:  op = OP_DIV_INIT;
      S_B_DIV:   op = OP_DIV_STEP;
      S_B_WR:    op = OP_B_WR;
      S_R_START: op = OP_R_INIT;
      S_R_RDA:   op = OP_R_RDA;
      S_R_RDB:   op = OP_R_RDB;
      S_R_CHK:   op = OP_NONE;
      S_R_NEXT:  op = OP_R_NEXT;
      S_F_INIT:  op = OP_F_INIT;
      S_F_FIRST: op = OP_F_FIRST;
      S_F_SCAN:  op = OP_F_SCAN;
      S_F_DEC:   op = OP_S_INIT;
      S_S_RD:    op = OP_S_RD;
      S_S_WR:    op = OP_S_WR;
      S_FIN_OK:  op = OP_FIN_OK;
      S_FIN_ND:  op = OP_FIN_ND;
      S_CLR:     op = OP_CLR;
      S_FINISH:  if (st.out_free) op = OP_LOAD;
      default:   op = OP_NONE;
    endcase
  end

endmodule

/* hdl/cbz_datapath.sv */
module cbz_datapath #(
  parameter int SYMBOL_COUNT  = cbz_pkg::SYMBOL_COUNT_DEF,
  parameter int COUNT_BITS    = cbz_pkg::COUNT_BITS_DEF,
  parameter int MAX_PROB_BITS = cbz_pkg::MAX_PROB_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  cbz_pkg::dp_op_t     op,
  output cbz_pkg::dp_status_t st,
  input  logic                cfg_wr_en,
  input  logic [4:0]          cfg_wr_data,
  input  logic [7:0]          symbol,
  input  logic [8:0]          entry_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         entry_value,
  output logic [1:0]          status
);
  import cbz_pkg::*;

  localparam int SYM_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int TA_W  = $clog2(SYMBOL_COUNT + 1);
  localparam int CB    = COUNT_BITS;
  localparam int MPB   = MAX_PROB_BITS;
  localparam int PW    = MPB + CB;
  localparam int DCW   = $clog2(MPB);

  // Histogram and table storage.
  logic [CB-1:0]           cnt_mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] cnt_vld;
  logic [TBL_W-1:0]        tbl [SYMBOL_COUNT + 1];

  logic [4:0]       pb_q;
  logic [7:0]       sym_q;
  logic [8:0]       idx_q;
  logic [CB-1:0]    total;
  logic             ovf;
  logic [CB-1:0]    cq;
  logic             cq_vld;
  logic [CB-1:0]    cnt_eff;
  logic [TBL_W-1:0] tq;
  logic [TA_W-1:0]  ptr, jp, hi, donor;
  logic             dec, found;
  logic [TBL_W-1:0] best, prev, a_val, width;
  logic [CB-1:0]    cum, rem;
  logic [PW-1:0]    prod;
  logic [MPB-1:0]   low, top_val;
  logic [DCW-1:0]   dcnt;
  logic [CB:0]      r2;
  logic             ge;
  logic [4:0]       pb_eff;
  logic [TBL_W-1:0] res_val;
  logic [1:0]       res_st;
  logic             sym_ok, idx_ok;

  logic [SYM_W-1:0] cnt_addr;
  logic [TA_W-1:0]  rd_addr, wr_addr;
  logic             wr_en;
  logic [TBL_W-1:0] wr_data;

  assign pb_eff  = (pb_q == 5'd0) ? 5'd1 :
                   (pb_q > 5'(MPB)) ? 5'(MPB) : pb_q;
  assign top_val = {MPB{1'b1}} >> (5'(MPB) - pb_eff);
  assign cnt_eff = cq_vld ? cq : '0;
  assign sym_ok  = {1'b0, sym_q} < 9'(SYMBOL_COUNT);
  assign idx_ok  = idx_q <= 9'(SYMBOL_COUNT);
  assign width   = tq - prev;
  assign r2      = {rem, low[MPB-1]};
  assign ge      = r2 >= {1'b0, total};

  always_comb begin
    st.total_zero = (total == '0);
    st.ptr_end    = (ptr == TA_W'(SYMBOL_COUNT));
    st.ptr_top    = (ptr == TA_W'(SYMBOL_COUNT - 1));
    st.div_last   = (dcnt == DCW'(MPB - 1));
    st.same       = (tq == a_val);
    st.jp_top     = (jp == TA_W'(SYMBOL_COUNT - 1));
    st.jp_hi      = (jp == hi);
    st.found      = found;
    st.out_free   = !out_valid || !out_stall;
  end

  always_comb begin
    cnt_addr = (op == OP_B_RD) ? ptr[SYM_W-1:0] : sym_q[SYM_W-1:0];
    case (op)
      OP_TBL_RD:  rd_addr = TA_W'(idx_q);
      OP_R_RDB:   rd_addr = TA_W'(ptr + 1'b1);
      OP_F_INIT:  rd_addr = '0;
      OP_F_FIRST: rd_addr = TA_W'(1);
      OP_F_SCAN:  rd_addr = TA_W'(jp + 2'd2);
      OP_S_RD:    rd_addr = jp;
      default:    rd_addr = ptr;
    endcase
    wr_en   = 1'b0;
    wr_addr = ptr;
    wr_data = '0;
    case (op)
      OP_ZF_WR: wr_en = 1'b1;
      OP_B_INIT: begin
        wr_en   = 1'b1;
        wr_addr = '0;
      end
      OP_B_WR: begin
        wr_en   = 1'b1;
        wr_addr = TA_W'(ptr + 1'b1);
        wr_data = TBL_W'(low);
      end
      OP_S_WR: begin
        wr_en   = 1'b1;
        wr_addr = jp;
        wr_data = dec ? tq - 1'b1 : tq + 1'b1;
      end
      default: ;
    endcase
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) tbl[wr_addr] <= wr_data;
    if (rd_addr <= TA_W'(SYMBOL_COUNT)) tq <= tbl[rd_addr];
  end

  // Histogram memory with valid bits standing in for the clear.
  always_ff @(posedge clk) begin
    cq     <= cnt_mem[cnt_addr];
    cq_vld <= cnt_vld[cnt_addr];
    if (op == OP_CNT_WR && sym_ok && total != '1) begin
      cnt_mem[cnt_addr] <= cnt_eff + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld   <= '0;
      total     <= '0;
      ovf       <= 1'b0;
      pb_q      <= PROB_BITS_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) pb_q <= cfg_wr_data;
      if (op == OP_CNT_WR && sym_ok) begin
        if (total == '1) begin
          ovf <= 1'b1;
        end else begin
          cnt_vld[cnt_addr] <= 1'b1;
          total             <= total + 1'b1;
        end
      end
      if (op == OP_CLR) begin
        cnt_vld <= '0;
        total   <= '0;
        ovf     <= 1'b0;
      end
      if (op == OP_LOAD)               out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_TAKE: begin
        sym_q <= symbol;
        idx_q <= entry_index;
      end
      OP_RD_RES: begin
        res_val <= idx_ok ? tq : '0;
        res_st  <= ST_OK;
      end
      OP_ZF_INIT: begin
        ptr     <= '0;
        res_val <= '0;
        res_st  <= ST_EMPTY;
      end
      OP_ZF_WR: ptr <= ptr + 1'b1;
      OP_B_INIT: begin
        ptr     <= '0;
        cum     <= '0;
        res_val <= '0;
      end
      OP_B_ACC: cum <= cum + cnt_eff;
      OP_B_MUL: prod <= PW'(top_val) * PW'(cum);
      OP_DIV_INIT: begin
        rem  <= prod[PW-1:MPB];
        low  <= prod[MPB-1:0];
        dcnt <= '0;
      end
      OP_DIV_STEP: begin
        rem  <= ge ? CB'(r2 - {1'b0, total}) : r2[CB-1:0];
        low  <= {low[MPB-2:0], ge};
        dcnt <= dcnt + 1'b1;
      end
      OP_B_WR:   ptr <= ptr + 1'b1;
      OP_R_INIT: ptr <= '0;
      OP_R_RDB:  a_val <= tq;
      OP_R_NEXT: ptr <= ptr + 1'b1;
      OP_F_INIT: found <= 1'b0;
      OP_F_FIRST: begin
        prev <= tq;
        jp   <= '0;
      end
      OP_F_SCAN: begin
        if (width > TBL_W'(1) && (!found || width < best)) begin
          best  <= width;
          donor <= jp;
          found <= 1'b1;
        end
        prev <= tq;
        jp   <= jp + 1'b1;
      end
      OP_S_INIT: begin
        if (donor < ptr) begin
          jp  <= TA_W'(donor + 1'b1);
          hi  <= ptr;
          dec <= 1'b1;
        end else begin
          jp  <= TA_W'(ptr + 1'b1);
          hi  <= donor;
          dec <= 1'b0;
        end
      end
      OP_S_WR:   jp <= jp + 1'b1;
      OP_FIN_OK: res_st <= ovf ? ST_OVERFLOW : ST_OK;
      OP_FIN_ND: res_st <= ST_NO_DONOR;
      OP_LOAD: begin
        entry_value <= res_val;
        status      <= res_st;
      end
      default: ;
    endcase
  end

endmodule

/* hdl/cdf_builder_with_zero_stealing_top.sv */
// Channel  Handshake            Payload
// in       in_valid / in_stall  opcode, symbol, entry_index
// out      out_valid / out_stall entry_value, status
// cfg      cfg_wr_en            cfg_wr_data (prob_bits)
//
// A count transfer is bounded by the histogram read-modify-write.
// A read transfer reads the table entry and registers the result before the output handoff.
// A build scales every symbol through the bit-serial divider, then for each zero-width
// symbol runs a donor search and shifts table entries; an empty build zeroes the table
// and reports an empty status.
// Reset is synchronous and clears the histogram at once through per-entry valid bits.
// The output register holds a result under out_stall; counting continues meanwhile.
module cdf_builder_with_zero_stealing_top #(
  parameter int SYMBOL_COUNT  = cbz_pkg::SYMBOL_COUNT_DEF,
  parameter int COUNT_BITS    = cbz_pkg::COUNT_BITS_DEF,
  parameter int MAX_PROB_BITS = cbz_pkg::MAX_PROB_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [7:0]  symbol,
  input  logic [8:0]  entry_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] entry_value,
  output logic [1:0]  status
);
  import cbz_pkg::*;

  // The controller sequences one datapath operation per cycle and the datapath
  // reports the conditions that steer it.
  dp_op_t     op;
  dp_status_t st;

  cbz_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .opcode   (opcode),
    .st       (st),
    .op       (op)
  );

  cbz_datapath #(
    .SYMBOL_COUNT  (SYMBOL_COUNT),
    .COUNT_BITS    (COUNT_BITS),
    .MAX_PROB_BITS (MAX_PROB_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .st          (st),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .symbol      (symbol),
    .entry_index (entry_index),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .entry_value (entry_value),
    .status      (status)
  );

endmodule
